// ===== hdl/overlap_reference_count_table_core_macros.svh =====
// Assertion macros for the reference count table.
// Included by every file that checks its own logic; needs a clock named clk and reset rst.
`ifndef OVERLAP_REFERENCE_COUNT_TABLE_CORE_MACROS_SVH
`define OVERLAP_REFERENCE_COUNT_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ORTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ortc assertion failed");
`define ORTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ortc assertion failed");
`else
`define ORTC_ASSERT_NOW(lbl, ante, cons)
`define ORTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/ortc_pkg.sv =====
// Shared types and constants of the reference count table.
// No dependencies; used by the cell, the controller and the top level.
`timescale 1ns / 1ps

package ortc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int ID_BITS_DEF    = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int ID_IN_W        = 32;
  localparam int CNT_OUT_W      = 16;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_SAT    = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_HOLD
  } state_t;

  // Token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic                 tok;
    logic                 ins;
    logic                 hit;
    logic                 chg;
    status_t              status;
    logic [CNT_OUT_W-1:0] cnt;
  } wave_t;

endpackage

// ===== hdl/ortc_cell.sv =====
// One table entry: key, count and valid bit, plus the wave register to the next cell.
// Depends on ortc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "overlap_reference_count_table_core_macros.svh"

module ortc_cell #(
  parameter int ID_BITS    = ortc_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = ortc_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ID_BITS-1:0] key,
  input  ortc_pkg::op_t      op,
  input  ortc_pkg::wave_t    wave_in,
  output ortc_pkg::wave_t    wave_out
);
  import ortc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);

  logic                  valid;
  logic                  valid_next;
  logic [ID_BITS-1:0]    entry_key;
  logic [ID_BITS-1:0]    entry_key_next;
  logic [COUNT_BITS-1:0] entry_count;
  logic [COUNT_BITS-1:0] entry_count_next;
  wave_t                 wave_next;
  logic                  match;

  assign match = valid && (entry_key == key);

  always_comb begin
    valid_next       = valid;
    entry_key_next   = entry_key;
    entry_count_next = entry_count;
    wave_next        = wave_in;
    // a claimed wave passes untouched
    if (wave_in.tok && !wave_in.hit) begin
      if (!wave_in.ins) begin
        if (match) begin
          wave_next.hit = 1'b1;
          if (op == OP_ADD) begin
            if (entry_count == CMAX) begin
              wave_next.status = STAT_SAT;
            end else begin
              entry_count_next = entry_count + ONE;
            end
          end else begin
            if (entry_count <= ONE) begin
              valid_next       = 1'b0;
              entry_count_next = '0;
              wave_next.chg    = 1'b1;
            end else begin
              entry_count_next = entry_count - ONE;
            end
          end
          wave_next.cnt = CNT_OUT_W'(entry_count_next);
        end
      end else if (!valid) begin
        // first free entry takes the new key
        valid_next       = 1'b1;
        entry_key_next   = key;
        entry_count_next = ONE;
        wave_next.hit    = 1'b1;
        wave_next.chg    = 1'b1;
        wave_next.cnt    = CNT_OUT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      wave_out <= '0;
    end else begin
      valid    <= valid_next;
      wave_out <= wave_next;
    end
  end

  always_ff @(posedge clk) begin
    entry_key   <= entry_key_next;
    entry_count <= entry_count_next;
  end

  `ORTC_ASSERT_NOW(a_valid_set_by_fill, $rose(valid), $past(wave_in.tok && wave_in.ins))
  `ORTC_ASSERT_NEXT(a_claimed_wave_no_change, wave_in.tok && wave_in.hit, $stable(valid))
  `ORTC_ASSERT_NEXT(a_idle_cell_holds, !wave_in.tok, $stable(valid) && !wave_out.tok)

endmodule

// ===== hdl/ortc_ctrl.sv =====
// Sequencer: takes a word, launches the lookup and fill waves, builds the result word.
// Depends on ortc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "overlap_reference_count_table_core_macros.svh"

module ortc_ctrl #(
  parameter int ID_BITS = ortc_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [ortc_pkg::ID_IN_W-1:0]    object_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            membership_changed,
  output logic [1:0]                      status,
  output logic [ortc_pkg::CNT_OUT_W-1:0]  count_after,
  output logic [ID_BITS-1:0]              key,
  output ortc_pkg::op_t                   op,
  output ortc_pkg::wave_t                 launch,
  input  ortc_pkg::wave_t                 tail
);
  import ortc_pkg::*;

  state_t               state;
  state_t               state_next;
  wave_t                launch_next;
  logic                 pend_load;
  logic                 out_load;
  logic                 res_chg;
  status_t              res_status;
  logic [CNT_OUT_W-1:0] res_cnt;
  logic                 pend_chg;
  status_t              pend_status;
  logic [CNT_OUT_W-1:0] pend_cnt;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (tail.tok) begin
          if (!tail.hit && op == OP_ADD) state_next = ST_FILL;
          else state_next = ST_HOLD;
        end
      end
      ST_FILL: begin
        if (tail.tok) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    launch_next = '0;
    pend_load   = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        launch_next.tok = in_valid;
      end
      ST_SCAN: begin
        if (tail.tok) begin
          if (!tail.hit && op == OP_ADD) begin
            launch_next.tok = 1'b1;
            launch_next.ins = 1'b1;
          end else begin
            pend_load = 1'b1;
          end
        end
      end
      ST_FILL: begin
        pend_load = tail.tok;
      end
      ST_HOLD: begin
        out_load = !out_valid || !out_stall;
      end
      default: launch_next = '0;
    endcase
  end

  // unclaimed wave: full table on add, absent key on remove
  always_comb begin
    if (tail.hit) begin
      res_chg    = tail.chg;
      res_status = tail.status;
      res_cnt    = tail.cnt;
    end else begin
      res_chg    = 1'b0;
      res_status = (op == OP_ADD) ? STAT_FULL : STAT_ABSENT;
      res_cnt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launch    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      key <= ID_BITS'(object_id);
      op  <= op_t'(func);
    end
    if (pend_load) begin
      pend_chg    <= res_chg;
      pend_status <= res_status;
      pend_cnt    <= res_cnt;
    end
    if (out_load) begin
      membership_changed <= pend_chg;
      status             <= pend_status;
      count_after        <= pend_cnt;
    end
  end

  `ORTC_ASSERT_NEXT(a_accept_launches, in_valid && !in_stall, launch.tok && !launch.ins)
  `ORTC_ASSERT_NEXT(a_launch_pulse, launch.tok, !launch.tok)
  `ORTC_ASSERT_NOW(a_out_from_hold, $rose(out_valid), $past(state == ST_HOLD))

endmodule

// ===== hdl/overlap_reference_count_table_core.sv =====
// Reference count table: a row of ENTRIES cells; a token walks the row one cell per cycle.
// A hit, a remove or a miss on remove takes one walk of the row from accept to result; an add that
// inserts or finds the table full takes a second walk, which looks for a free cell.
// A new word waits until the last result is in the output register; a stalled result delays the next.
// Reset (synchronous, rst high): all valid bits clear, no token in flight, output empty.
`timescale 1ns / 1ps

module overlap_reference_count_table_core #(
  parameter int ENTRIES    = ortc_pkg::ENTRIES_DEF,
  parameter int ID_BITS    = ortc_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = ortc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [ortc_pkg::ID_IN_W-1:0]   object_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           membership_changed,
  output logic [1:0]                     status,
  output logic [ortc_pkg::CNT_OUT_W-1:0] count_after
);
  import ortc_pkg::*;

  logic [ID_BITS-1:0] key;
  op_t                op;
  wave_t              chain [ENTRIES+1];

  ortc_ctrl #(
    .ID_BITS(ID_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .object_id          (object_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .membership_changed (membership_changed),
    .status             (status),
    .count_after        (count_after),
    .key                (key),
    .op                 (op),
    .launch             (chain[0]),
    .tail               (chain[ENTRIES])
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ortc_cell #(
      .ID_BITS   (ID_BITS),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .op      (op),
      .wave_in (chain[i]),
      .wave_out(chain[i+1])
    );
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for overlap_reference_count_table_core: adds and removes of object ids.
// Depends on ortc_pkg for the operation and status codes; the core's default sizes are used.
`timescale 1ns / 1ps

module testbench;
  import ortc_pkg::*;

  localparam int TBL_DEPTH   = ENTRIES_DEF;
  localparam int KEY_W       = ID_BITS_DEF;
  localparam int CNT_W       = COUNT_BITS_DEF;
  localparam int POOL_SIZE   = 24;
  localparam int RAND_WORDS  = 400;
  localparam int TAIL_WORDS  = 40;
  localparam int DRAIN_WAIT  = 2 * TBL_DEPTH + 4 + 10;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [31:0] SAT_ID = 32'h8000_0001;

  typedef struct {
    op_t         op;
    logic [31:0] id;
  } overlap_req_t;

  typedef struct {
    logic                 changed;
    status_t              stat;
    logic [CNT_OUT_W-1:0] cnt;
  } count_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic func = 1'b0;
  logic [ID_IN_W-1:0] object_id = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic membership_changed;
  logic [1:0] status;
  logic [CNT_OUT_W-1:0] count_after;

  overlap_req_t  overlap_reqs[$];
  count_report_t count_reports[$];

  // Shadow of the id table
  logic [KEY_W-1:0] tbl_key   [TBL_DEPTH];
  logic [CNT_W-1:0] tbl_count [TBL_DEPTH];
  bit               tbl_used  [TBL_DEPTH];

  logic [31:0] id_pool [POOL_SIZE];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  offer_live = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  pressure_done = 1'b0;
  bit  idle_on = 1'b1;
  int  stretch_left = 0;

  overlap_reference_count_table_core dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .object_id          (object_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .membership_changed (membership_changed),
    .status             (status),
    .count_after        (count_after)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic count_report_t count_overlap(input op_t op, input logic [31:0] id);
    count_report_t    rep;
    logic [KEY_W-1:0] key;
    int               hit;
    int               spare;
    rep.changed = 1'b0;
    rep.stat = STAT_OK;
    rep.cnt = '0;
    key = id[KEY_W-1:0];
    hit = -1;
    spare = -1;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (tbl_used[i]) begin
        if (hit < 0 && tbl_key[i] == key) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (op == OP_ADD) begin
      if (hit >= 0) begin
        if (tbl_count[hit] == CNT_MAX) rep.stat = STAT_SAT;
        else tbl_count[hit] = tbl_count[hit] + 1'b1;
        rep.cnt = CNT_OUT_W'(tbl_count[hit]);
      end else if (spare >= 0) begin
        tbl_used[spare] = 1'b1;
        tbl_key[spare] = key;
        tbl_count[spare] = CNT_W'(1);
        rep.changed = 1'b1;
        rep.cnt = CNT_OUT_W'(1);
      end else begin
        rep.stat = STAT_FULL;
      end
    end else begin
      if (hit < 0) begin
        rep.stat = STAT_ABSENT;
      end else if (tbl_count[hit] <= CNT_W'(1)) begin
        tbl_count[hit] = '0;
        tbl_used[hit] = 1'b0;
        rep.changed = 1'b1;
      end else begin
        tbl_count[hit] = tbl_count[hit] - 1'b1;
        rep.cnt = CNT_OUT_W'(tbl_count[hit]);
      end
    end
    return rep;
  endfunction

  task automatic push_req(input op_t op, input logic [31:0] id);
    overlap_req_t req;
    req.op = op;
    req.id = id;
    overlap_reqs.push_back(req);
  endtask

  // Stimulus and end of run
  initial begin
    int add_pct;
    int pick;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'hAAAA_AAAA;
    id_pool[3] = 32'h5555_5555;
    id_pool[4] = 32'h0000_0001;
    id_pool[5] = 32'h8000_0000;
    id_pool[6] = 32'hFFFF_FFFE;
    id_pool[7] = SAT_ID;
    for (int i = 8; i < POOL_SIZE; i++) id_pool[i] = $urandom();

    // remove from an empty table, insert, raise, lower, free
    push_req(OP_REMOVE, id_pool[0]);
    push_req(OP_ADD, id_pool[0]);
    push_req(OP_ADD, id_pool[0]);
    push_req(OP_REMOVE, id_pool[0]);
    push_req(OP_REMOVE, id_pool[0]);
    // fill every entry, then refuse one more
    for (int i = 0; i < TBL_DEPTH; i++) push_req(OP_ADD, id_pool[i]);
    push_req(OP_ADD, id_pool[TBL_DEPTH]);
    // free a middle entry and take it again
    push_req(OP_REMOVE, id_pool[1]);
    push_req(OP_ADD, id_pool[TBL_DEPTH]);
    push_req(OP_REMOVE, id_pool[TBL_DEPTH]);

    // raise one stored id a few times, then step back
    for (int i = 0; i < 4; i++) push_req(OP_ADD, SAT_ID);
    push_req(OP_REMOVE, SAT_ID);
    push_req(OP_ADD, SAT_ID);
    push_req(OP_ADD, SAT_ID);

    add_pct = 50;
    for (int n = 0; n < RAND_WORDS; n++) begin
      // swing between filling and draining the table
      if (n % 50 == 0) begin
        pick = $urandom_range(0, 2);
        add_pct = 25 + 25 * pick;
      end
      if ($urandom_range(0, 99) < 8) begin
        push_req(OP_REMOVE, $urandom());
      end else begin
        push_req(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE,
                 id_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end
    end

    @(negedge rst);
    while (overlap_reqs.size() != 0 || count_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && count_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Idle on/off stretches shared by both sides
  always @(negedge clk) begin
    if (stretch_left == 0) begin
      idle_on = ($urandom_range(0, 2) != 0);
      stretch_left = $urandom_range(50, 400);
    end else begin
      stretch_left--;
    end
  end

  // Driver: offer the head of the queue, hold it until taken
  always @(negedge clk) begin
    if (!rst) begin
      if (offer_live) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (overlap_reqs.size() > 0) begin
        if (idle_on && overlap_reqs.size() > TAIL_WORDS && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          func <= overlap_reqs[0].op;
          object_id <= overlap_reqs[0].id;
          offer_live = 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (!rst) begin
      if (!pressure_done && overlap_reqs.size() <= RAND_WORDS / 2) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && overlap_reqs.size() > TAIL_WORDS
                   && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Input acceptance, prediction and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        count_reports.push_back(count_overlap(op_t'(func), object_id));
        void'(overlap_reqs.pop_front());
        offer_live = 1'b0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    count_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (count_reports.size() == 0) begin
        $error("unexpected result: membership_changed %0d status %0d count_after %0d",
               membership_changed, status, count_after);
        mismatches++;
      end else begin
        want = count_reports.pop_front();
        if (membership_changed !== want.changed) begin
          $error("membership_changed: expected %0d, actual %0d", want.changed,
                 membership_changed);
          mismatches++;
        end
        if (status !== want.stat) begin
          $error("status: expected %0d, actual %0d", want.stat, status);
          mismatches++;
        end
        if (count_after !== want.cnt) begin
          $error("count_after: expected %0d, actual %0d", want.cnt, count_after);
          mismatches++;
        end
      end
    end
  end

endmodule

// ===== overlap_reference_count_table_core.f =====
+incdir+hdl
hdl/ortc_pkg.sv
hdl/ortc_cell.sv
hdl/ortc_ctrl.sv
hdl/overlap_reference_count_table_core.sv
bench/testbench.sv
